@@ hw/rtl/dpdp_pkg.sv @@
// Shared constants and helpers for the pairwise distance projection block.
`default_nettype none
package dpdp_pkg;
   localparam int MaxPoints = 16;
   localparam int MaxPairs  = MaxPoints * (MaxPoints - 1) / 2;
   localparam int PtIdxW    = $clog2(MaxPoints);
   localparam int CntW      = $clog2(MaxPoints + 1);
   localparam int PairIdxW  = $clog2(MaxPairs);

   localparam logic [1:0] CSR_RADIUS    = 2'd0;
   localparam logic [1:0] CSR_MAX_ITER  = 2'd1;
   localparam logic [1:0] CSR_TOLERANCE = 2'd2;

   // Unit operation codes.
   localparam logic [1:0] OP_SQRT = 2'd0;
   localparam logic [1:0] OP_DIV  = 2'd1;

   typedef struct packed {
      logic        go;
      logic [1:0]  op;
      logic [63:0] a;
      logic [31:0] b;
   } unit_req_type;

   // Saturate a 34-bit signed sum to 32 bits.
   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > 34'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else if (v < -34'sh0_8000_0000) r = -32'sh8000_0000;
      else r = v[31:0];
      return r;
   endfunction

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      logic [32:0] t;
      t = v[31] ? (33'd0 - {v[31], v}) : {1'b0, v};
      return t[31:0];
   endfunction
endpackage
`default_nettype wire

@@ hw/rtl/dykstra_pairwise_distance_projection.sv @@
// Top level: point loader, Dykstra sweep sequencer and result emitter.
//  channel | ports                                  | transfer
//  request | req_point_x/y, req_last                | start && !busy
//  result  | rsp_out_x/y, rsp_out_last, rsp_sweeps_done | rsp_valid, one cycle
//  config  | csr_we, csr_index, csr_wdata            | csr_we
// A point without last is stored while the set has room. With last, the corrections are
// cleared, then each sweep visits every pair: a pair that is shrunk takes two roots and
// two divisions on the shared unit, plus reads and write-back; a pair within the radius
// takes the two roots and skips the divisions.
// Synchronous reset returns to idle with an empty set. Results leave one at a time after
// the final sweep; the receiver cannot stall.
`default_nettype none
module dykstra_pairwise_distance_projection
   import dpdp_pkg::*;
(
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  wire signed [31:0]  req_point_x,
   input  wire signed [31:0]  req_point_y,
   input  wire                req_last,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic               rsp_out_last,
   output logic [9:0]         rsp_sweeps_done,
   input  wire                csr_we,
   input  wire [1:0]          csr_index,
   input  wire [15:0]         csr_wdata
);
   localparam logic [3:0] S_IDLE = 4'd0, S_CLR = 4'd1, S_RD = 4'd2, S_RDW = 4'd3,
                          S_N1 = 4'd4, S_DX = 4'd5, S_DY = 4'd6, S_CALC = 4'd7,
                          S_N2 = 4'd8, S_WB = 4'd9, S_EMIT = 4'd10, S_EMW = 4'd11,
                          S_NEXT = 4'd12;

   logic [14:0] radius_ff;
   logic [9:0]  maxit_ff;
   logic [15:0] tol_ff;
   logic [3:0]  st_ff, st_in;
   logic [CntW-1:0] n_ff;
   logic [PtIdxW-1:0] a_ff, b_ff;
   logic [PairIdxW-1:0] k_ff;
   logic [9:0]  sweep_ff;
   logic [31:0] big_ff;
   logic        phase_ff;   // read phase: 0 reads point a, 1 reads point b
   logic signed [31:0] pax_ff, pay_ff, pbx_ff, pby_ff, rx_ff, ry_ff, cx_ff, cy_ff;
   logic [31:0] nr_ff;
   logic        ustarted_ff;

   // Point and correction memories.
   logic pt_we, c_we;
   logic [PtIdxW-1:0] pt_addr;
   logic [PairIdxW-1:0] c_addr;
   logic [31:0] pxw, pyw, pxr, pyr, cxw, cyw, cxr, cyr;

   dpdp_ram #(.Width(32), .Depth(MaxPoints)) u_px (.clock, .we(pt_we), .addr(pt_addr),
      .wdata(pxw), .rdata(pxr));
   dpdp_ram #(.Width(32), .Depth(MaxPoints)) u_py (.clock, .we(pt_we), .addr(pt_addr),
      .wdata(pyw), .rdata(pyr));
   dpdp_ram #(.Width(32), .Depth(MaxPairs)) u_cx (.clock, .we(c_we), .addr(c_addr),
      .wdata(cxw), .rdata(cxr));
   dpdp_ram #(.Width(32), .Depth(MaxPairs)) u_cy (.clock, .we(c_we), .addr(c_addr),
      .wdata(cyw), .rdata(cyr));

   unit_req_type ureq;
   logic         udone;
   logic [63:0]  ures;
   dpdp_unit u_unit (.clock, .reset, .req(ureq), .done(udone), .result(ures));

   // Shared datapath helpers.
   logic [31:0] sig_lo;
   logic [32:0] sig_full;
   logic [31:0] mrx, mry;
   logic [63:0] sqx, sqy;
   logic [63:0] sqsum;
   logic signed [31:0] ex, ey;
   logic [31:0] qx_ff;
   logic signed [31:0] hx, hy;
   logic accept;

   assign accept   = start && !busy;
   assign busy     = st_ff != S_IDLE;
   assign sig_full = {2'b00, radius_ff, 16'd0};
   assign sig_lo   = sig_full[31:0];
   assign mrx      = mag32(rx_ff);
   assign mry      = mag32(ry_ff);
   assign sqx      = (st_ff == S_N2) ? mag32(ex) * mag32(ex) : mrx * mrx;
   assign sqy      = (st_ff == S_N2) ? mag32(ey) * mag32(ey) : mry * mry;
   assign sqsum    = sqx + sqy;
   assign ex       = sat32(34'(rx_ff) - 34'(cx_ff));
   assign ey       = sat32(34'(ry_ff) - 34'(cy_ff));
   assign hx       = ex / 2;
   assign hy       = ey / 2;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 15'd8;
         maxit_ff  <= 10'd200;
         tol_ff    <= 16'd7;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RADIUS:    radius_ff <= csr_wdata[14:0];
            CSR_MAX_ITER:  maxit_ff  <= csr_wdata[9:0];
            CSR_TOLERANCE: tol_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Memory port control.
   always_comb begin
      pt_we = 1'b0; c_we = 1'b0;
      pt_addr = phase_ff ? b_ff : a_ff;
      c_addr = k_ff;
      pxw = req_point_x; pyw = req_point_y;
      cxw = '0; cyw = '0;
      case (st_ff)
         S_IDLE: begin
            pt_addr = n_ff[PtIdxW-1:0];
            pt_we   = accept && (n_ff < CntW'(MaxPoints));
         end
         S_CLR: c_we = 1'b1;
         S_WB: begin
            pt_we = 1'b1;
            c_we  = !phase_ff;
            cxw   = rx_ff; cyw = ry_ff;
            if (!phase_ff) begin
               pxw = sat32(34'(pax_ff) + 34'(hx));
               pyw = sat32(34'(pay_ff) + 34'(hy));
            end else begin
               pxw = sat32(34'(pbx_ff) - 34'(hx));
               pyw = sat32(34'(pby_ff) - 34'(hy));
            end
         end
         default: ;
      endcase
   end

   // Sequencer.
   logic last_pair, dx_go;
   assign last_pair = (32'(b_ff) + 32'd1 >= 32'(n_ff)) && (32'(a_ff) + 32'd2 >= 32'(n_ff));
   always_comb begin
      st_in = st_ff;
      ureq  = '0;
      dx_go = 1'b0;
      case (st_ff)
         S_IDLE: if (accept && req_last) st_in = S_CLR;
         S_CLR: if (32'(k_ff) == MaxPairs - 1) st_in = (n_ff < CntW'(2)) ? S_NEXT : S_RD;
         S_RD: st_in = S_RDW;
         S_RDW: st_in = phase_ff ? S_N1 : S_RD;
         S_N1: begin
            if (!ustarted_ff) begin
               ureq.go = 1'b1; ureq.op = OP_SQRT; ureq.a = sqsum;
            end else if (udone) begin
               if (ures[32:0] <= sig_full) st_in = S_CALC;
               else begin st_in = S_DX; dx_go = 1'b1; end
            end
         end
         S_DX: if (udone) st_in = S_DY;
         S_DY: if (udone) st_in = S_CALC;
         S_CALC: st_in = S_N2;
         S_N2: begin
            if (!ustarted_ff) begin
               ureq.go = 1'b1; ureq.op = OP_SQRT; ureq.a = sqsum;
            end else if (udone) st_in = S_WB;
         end
         S_WB: if (phase_ff) st_in = last_pair ? S_NEXT : S_RD;
         S_NEXT: st_in = S_NEXT;
         S_EMIT: st_in = S_EMW;
         S_EMW: st_in = (32'(a_ff) + 32'd1 >= 32'(n_ff)) ? S_IDLE : S_EMIT;
         default: st_in = S_IDLE;
      endcase
      // the norm is still on the unit output in the cycle it finishes
      if (dx_go) begin
         ureq.go = 1'b1; ureq.op = OP_DIV; ureq.a = 64'(mrx) * 64'(ures[31:0] - sig_lo);
         ureq.b = ures[31:0];
      end else if (st_ff == S_DX && udone) begin
         ureq.go = 1'b1; ureq.op = OP_DIV; ureq.a = 64'(mry) * 64'(nr_ff - sig_lo);
         ureq.b = nr_ff;
      end
      if (st_ff == S_NEXT) begin
         if (big_ff < 32'(tol_ff) || sweep_ff >= maxit_ff) st_in = S_EMIT;
         else st_in = (n_ff < CntW'(2)) ? S_NEXT : S_RD;
      end
   end

   logic [9:0] sweep_cap;
   assign sweep_cap = sweep_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         n_ff  <= '0;
         rsp_valid <= 1'b0;
         ustarted_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         rsp_valid <= (st_ff == S_EMW);
         ustarted_ff <= (st_in == st_ff) && (ureq.go || ustarted_ff) && !udone;
         if (st_ff == S_IDLE && accept && n_ff < CntW'(MaxPoints)) n_ff <= n_ff + 1'b1;
         if (st_ff == S_EMW && st_in == S_IDLE) n_ff <= '0;
      end
      case (st_ff)
         S_IDLE: begin
            k_ff <= '0; a_ff <= '0; b_ff <= PtIdxW'(1); phase_ff <= 1'b0;
            sweep_ff <= 10'd1; big_ff <= '0;
         end
         S_CLR: if (st_in != S_CLR) k_ff <= '0; else k_ff <= k_ff + 1'b1;
         S_RDW: begin
            if (!phase_ff) begin pax_ff <= pxr; pay_ff <= pyr; cx_ff <= cxr; cy_ff <= cyr; end
            else begin
               pbx_ff <= pxr; pby_ff <= pyr;
               rx_ff <= sat32(34'($signed(pxr)) - 34'(pax_ff) + 34'(cx_ff));
               ry_ff <= sat32(34'($signed(pyr)) - 34'(pay_ff) + 34'(cy_ff));
            end
            phase_ff <= !phase_ff;
         end
         S_N1: if (udone) begin
            nr_ff <= ures[31:0];
            if (ures[32:0] <= sig_full) begin rx_ff <= '0; ry_ff <= '0; end
         end
         S_DX: if (udone) qx_ff <= ures[31:0];
         S_DY: if (udone) begin
            rx_ff <= rx_ff[31] ? -qx_ff : qx_ff;
            ry_ff <= ry_ff[31] ? -ures[31:0] : ures[31:0];
         end
         S_N2: if (udone) begin
            if (ures[63:32] != 0) begin
               if (big_ff != 32'hFFFF_FFFF) big_ff <= 32'hFFFF_FFFF;
            end else if (ures[31:0] > big_ff) big_ff <= ures[31:0];
         end
         S_WB: begin
            phase_ff <= !phase_ff;
            if (phase_ff) begin
               k_ff <= k_ff + 1'b1;
               if (32'(b_ff) + 32'd1 >= 32'(n_ff)) begin
                  a_ff <= a_ff + 1'b1; b_ff <= a_ff + PtIdxW'(2);
               end else b_ff <= b_ff + 1'b1;
            end
         end
         S_NEXT: begin
            k_ff <= '0; a_ff <= '0; b_ff <= PtIdxW'(1); phase_ff <= 1'b0;
            if (st_in != S_EMIT) begin sweep_ff <= sweep_ff + 1'b1; big_ff <= '0; end
         end
         S_EMIT: phase_ff <= 1'b0;
         S_EMW: a_ff <= a_ff + 1'b1;
         default: ;
      endcase
   end

   assign rsp_out_x = pxr;
   assign rsp_out_y = pyr;
   always_ff @(posedge clock) begin
      rsp_out_last    <= (st_ff == S_EMW) && (32'(a_ff) + 32'd1 >= 32'(n_ff));
      rsp_sweeps_done <= (maxit_ff == 10'd0) ? 10'd1 : sweep_cap;
   end

`ifndef SYNTHESIS
   a_last_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_out_last |-> rsp_valid) else $error("last without valid");
   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("result while idle");
   a_count_ok: assert property (@(posedge clock) disable iff (reset)
      n_ff <= CntW'(MaxPoints)) else $error("count overflow");
`endif
endmodule
`default_nettype wire

@@ hw/rtl/dpdp_ram.sv @@
// Generic single port RAM with registered read.
`default_nettype none
module dpdp_ram #(
   parameter int Width = 32,
   parameter int Depth = 16
) (
   input  wire                     clock,
   input  wire                     we,
   input  wire [$clog2(Depth)-1:0] addr,
   input  wire [Width-1:0]         wdata,
   output logic [Width-1:0]        rdata
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire

@@ hw/rtl/dpdp_unit.sv @@
// Shared iterative unit: 64-bit integer square root or 64/32 division, one bit per cycle.
`default_nettype none
module dpdp_unit
   import dpdp_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   input  unit_req_type req,
   output logic         done,
   output logic [63:0]  result
);
   logic        busy_ff, busy_in;
   logic [1:0]  op_ff, op_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] rem_ff, rem_in;   // sqrt: remaining value; div: dividend shifting
   logic [65:0] acc_ff, acc_in;   // sqrt: partial remainder; div: partial remainder
   logic [31:0] dvs_ff, dvs_in;
   logic [63:0] quo_ff, quo_in;
   logic [65:0] trial;
   logic [65:0] sh_acc;

   always_comb begin
      busy_in = busy_ff;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      acc_in  = acc_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      done    = 1'b0;
      trial   = '0;
      sh_acc  = '0;
      if (busy_ff) begin
         if (op_ff == OP_SQRT) begin
            // Digit-by-digit root: two bits of input per step, 32 steps.
            sh_acc = {acc_ff[63:0], rem_ff[63:62]};
            trial  = {quo_ff[63:0], 2'b01};
            if (sh_acc >= trial) begin
               acc_in = sh_acc - trial;
               quo_in = {quo_ff[62:0], 1'b1};
            end else begin
               acc_in = sh_acc;
               quo_in = {quo_ff[62:0], 1'b0};
            end
            rem_in = {rem_ff[61:0], 2'b00};
            cnt_in = cnt_ff - 6'd2;
            if (cnt_ff == 6'd1) begin
               busy_in = 1'b0;
               done    = 1'b1;
            end
         end else begin
            // Restoring division, one quotient bit per step.
            sh_acc = {acc_ff[64:0], rem_ff[63]};
            if (sh_acc >= {34'd0, dvs_ff}) begin
               acc_in = sh_acc - {34'd0, dvs_ff};
               quo_in = {quo_ff[62:0], 1'b1};
            end else begin
               acc_in = sh_acc;
               quo_in = {quo_ff[62:0], 1'b0};
            end
            rem_in = {rem_ff[62:0], 1'b0};
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               busy_in = 1'b0;
               done    = 1'b1;
            end
         end
      end
      result = quo_in;
      // A new operation may be loaded in the cycle the previous one finishes.
      if (req.go) begin
         busy_in = 1'b1;
         op_in   = req.op;
         cnt_in  = 6'd63;
         rem_in  = req.a;
         acc_in  = '0;
         dvs_in  = req.b;
         quo_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      acc_ff <= acc_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

`ifndef SYNTHESIS
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      req.go |-> (!busy_ff || done)) else $error("unit started while busy");
   a_done_ends: assert property (@(posedge clock) disable iff (reset)
      (done && !req.go) |=> !busy_ff) else $error("unit busy after done");
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (req.go && req.op == OP_DIV) |-> req.b != 32'd0) else $error("divide by zero");
`endif
endmodule
`default_nettype wire

@@ test/dykstra_pairwise_distance_projection_tb.sv @@
// Self-checking testbench for the Dykstra pairwise distance projection block.
`default_nettype none
module dykstra_pairwise_distance_projection_tb
   import dpdp_pkg::*;
();

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic               last;
   } point_type;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic               last;
      logic [9:0]         sweeps;
   } proj_point_type;

   localparam int StallLimit = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [31:0] req_point_x = '0;
   logic signed [31:0] req_point_y = '0;
   logic req_last = 1'b0;
   logic rsp_valid;
   logic signed [31:0] rsp_out_x, rsp_out_y;
   logic rsp_out_last;
   logic [9:0] rsp_sweeps_done;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   dykstra_pairwise_distance_projection dut (.*);

   always #5 clock = ~clock;

   point_type      point_queue[$];
   proj_point_type proj_queue[$];
   int unsigned sent_cnt = 0, taken_cnt = 0, gap = 0, error_cnt = 0, stall_cnt = 0;
   bit          quiet = 0;

   // predictor state
   logic [14:0] m_radius = 15'd8;
   logic [9:0]  m_max_iter = 10'd200;
   logic [15:0] m_tolerance = 16'd7;
   int          m_px[MaxPoints], m_py[MaxPoints];
   int          m_cx[MaxPairs], m_cy[MaxPairs];
   int unsigned m_count = 0;

   function automatic int clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return -32'sh8000_0000;
      return int'(v);
   endfunction

   function automatic longint unsigned magnitude(int v);
      return v < 0 ? longint'(-longint'(v)) : longint'(v);
   endfunction

   function automatic longint unsigned int_root(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic longint unsigned vec_norm(int x, int y);
      longint unsigned ax, ay;
      ax = magnitude(x);
      ay = magnitude(y);
      return int_root(ax * ax + ay * ay);
   endfunction

   function automatic int shrink_to(int r, longint unsigned nrm, longint unsigned rad);
      longint unsigned q;
      q = (magnitude(r) * (nrm - rad)) / nrm;
      return r < 0 ? int'(-longint'(q)) : int'(q);
   endfunction

   // Dykstra sweeps over the stored set; returns sweep count
   function automatic int unsigned project_set(int unsigned n);
      longint unsigned rad, nr, ch;
      int unsigned lim, k, big;
      int rx, ry, ex, ey;
      rad = longint'(m_radius) << 16;
      lim = (m_max_iter == 0) ? 1 : m_max_iter;
      for (int i = 0; i < MaxPairs; i++) begin
         m_cx[i] = 0;
         m_cy[i] = 0;
      end
      for (int unsigned s = 1; s <= lim; s++) begin
         k = 0;
         big = 0;
         for (int unsigned a = 0; a + 1 < n; a++) begin
            for (int unsigned b = a + 1; b < n; b++) begin
               rx = clamp32(longint'(m_px[b]) - m_px[a] + m_cx[k]);
               ry = clamp32(longint'(m_py[b]) - m_py[a] + m_cy[k]);
               nr = vec_norm(rx, ry);
               if (nr <= rad) begin
                  rx = 0;
                  ry = 0;
               end else begin
                  rx = shrink_to(rx, nr, rad);
                  ry = shrink_to(ry, nr, rad);
               end
               ex = clamp32(longint'(rx) - m_cx[k]);
               ey = clamp32(longint'(ry) - m_cy[k]);
               m_px[a] = clamp32(longint'(m_px[a]) + ex / 2);
               m_py[a] = clamp32(longint'(m_py[a]) + ey / 2);
               m_px[b] = clamp32(longint'(m_px[b]) - ex / 2);
               m_py[b] = clamp32(longint'(m_py[b]) - ey / 2);
               m_cx[k] = rx;
               m_cy[k] = ry;
               ch = vec_norm(ex, ey);
               if (ch > 64'hFFFF_FFFF) ch = 64'hFFFF_FFFF;
               if (int'(ch[31:0]) != 0 && ch[31:0] > big) big = ch[31:0];
               k++;
            end
         end
         if (big < m_tolerance) return s;
      end
      return lim;
   endfunction

   // store a point; on the final point compute the emitted set
   function automatic void predict_point(int x, int y, logic lst);
      int unsigned sw;
      proj_point_type p;
      if (m_count < MaxPoints) begin
         m_px[m_count] = x;
         m_py[m_count] = y;
         m_count++;
      end
      if (lst) begin
         sw = project_set(m_count);
         for (int unsigned k = 0; k < m_count; k++) begin
            p.x = m_px[k];
            p.y = m_py[k];
            p.last = (k + 1 == m_count);
            p.sweeps = sw[9:0];
            proj_queue.push_back(p);
         end
         m_count = 0;
      end
   endfunction

   task automatic report(string what, longint got, longint want);
      $display("MISMATCH %s: got %0d expected %0d", what, got, want);
      error_cnt++;
   endtask

   // driver: one point per transfer, random idle bursts
   always @(negedge clock) begin
      point_type it;
      if (!reset) begin
         if (start && taken_cnt != sent_cnt) begin
            // hold until the transfer happens
         end else if (gap > 0) begin
            gap--;
            start <= 1'b0;
         end else if (point_queue.size() > 0 && !quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(0, 8);
            start <= 1'b0;
         end else if (point_queue.size() > 0) begin
            it = point_queue.pop_front();
            req_point_x <= it.x;
            req_point_y <= it.y;
            req_last <= it.last;
            start <= 1'b1;
            sent_cnt++;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: predict on input transfers, check results, track config
   always @(posedge clock) begin
      proj_point_type e;
      bit moved;
      if (!reset) begin
         moved = 0;
         if (start && !busy) begin
            taken_cnt++;
            moved = 1;
            predict_point(req_point_x, req_point_y, req_last);
         end
         if (rsp_valid) begin
            moved = 1;
            if (proj_queue.size() == 0) begin
               report("unexpected result", 0, 0);
            end else begin
               e = proj_queue.pop_front();
               if (rsp_out_x !== e.x) report("out_x", rsp_out_x, e.x);
               if (rsp_out_y !== e.y) report("out_y", rsp_out_y, e.y);
               if (rsp_out_last !== e.last) report("out_last", rsp_out_last, e.last);
               if (rsp_sweeps_done !== e.sweeps)
                  report("sweeps_done", rsp_sweeps_done, e.sweeps);
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_RADIUS:    m_radius = csr_wdata[14:0];
               CSR_MAX_ITER:  m_max_iter = csr_wdata[9:0];
               CSR_TOLERANCE: m_tolerance = csr_wdata;
               default: ;
            endcase
         end
         stall_cnt = moved ? 0 : stall_cnt + 1;
         if (stall_cnt >= StallLimit) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   task automatic add_point(logic signed [31:0] x, logic signed [31:0] y, logic lst);
      point_type p;
      p.x = x;
      p.y = y;
      p.last = lst;
      point_queue.push_back(p);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_idle();
      while (point_queue.size() != 0 || sent_cnt != taken_cnt || proj_queue.size() != 0)
         @(posedge clock);
      repeat (30) @(negedge clock);
   endtask

   // random set: mostly clustered points near the radius, some full-range
   task automatic add_random_set(int unsigned n);
      logic signed [31:0] x, y;
      bit wide;
      wide = ($urandom_range(0, 3) == 0);
      for (int unsigned i = 0; i < n; i++) begin
         if (wide) begin
            x = $urandom;
            y = $urandom;
         end else begin
            x = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
            y = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
         end
         add_point(x, y, i + 1 == n);
      end
   endtask

   initial begin
      int unsigned rnd_items, n;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // extremes at reset config
      add_point(32'sh7FFF_FFFF, -32'sh8000_0000, 1'b1);
      add_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
      add_point(-32'sh8000_0000, -32'sh8000_0000, 1'b1);
      add_point(32'sh0, 32'sh0, 1'b0);
      add_point(32'sh0003_0000, 32'sh0, 1'b1);
      wait_idle();

      // zero limit acts as one sweep, zero radius
      csr_write(CSR_MAX_ITER, 16'd0);
      csr_write(CSR_RADIUS, 16'd0);
      add_point(32'sh0001_0000, -32'sh0002_0000, 1'b0);
      add_point(-32'sh0005_0000, 32'sh0000_8000, 1'b0);
      add_point(32'sh0, 32'sh0004_0000, 1'b1);
      wait_idle();

      // full store: the seventeenth point is dropped but still starts the run
      csr_write(CSR_RADIUS, 16'd32767);
      csr_write(CSR_TOLERANCE, 16'hFFFF);
      csr_write(CSR_MAX_ITER, 16'd1);
      add_random_set(17);
      wait_idle();

      // single point with zero tolerance runs to the largest limit
      csr_write(CSR_TOLERANCE, 16'd0);
      csr_write(CSR_MAX_ITER, 16'd1023);
      add_point($urandom, $urandom, 1'b1);
      wait_idle();

      // random phases with fresh settings
      rnd_items = 0;
      while (rnd_items < 104) begin
         csr_write(CSR_RADIUS,
            ($urandom_range(0, 7) == 0) ? 16'd32767 : 16'($urandom_range(0, 20)));
         csr_write(CSR_MAX_ITER, 16'($urandom_range(1, 8)));
         csr_write(CSR_TOLERANCE,
            ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 64)));
         quiet = (rnd_items > 80);
         for (int s = 0; s < 3; s++) begin
            n = $urandom_range(1, 4);
            add_random_set(n);
            rnd_items += n;
         end
         wait_idle();
      end

      repeat (50) @(posedge clock);
      if (error_cnt == 0 && proj_queue.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
`default_nettype wire
